/* sv/chtr_pkg.sv */
// Shared types, widths, constants and helper functions for the clustered hash table replace block.
// No dependencies; imported by every module of the block but the port checker.
`default_nettype none
package chtr_pkg;

    localparam int CHECK_W = 64;
    localparam int ENTRY_W = 48;
    localparam int SLOT_W  = CHECK_W + ENTRY_W;
    localparam int Q_W     = 10;

    localparam logic OP_PROBE = 1'b0;
    localparam logic OP_STORE = 1'b1;

    localparam logic [1:0] REG_GENERATION = 2'd0;
    localparam logic [1:0] REG_MATE_THR   = 2'd1;
    localparam logic [1:0] REG_EXACT      = 2'd2;

    localparam logic [5:0]  RST_GENERATION = 6'd0;
    localparam logic [14:0] RST_MATE_THR   = 15'd31000;
    localparam logic [1:0]  RST_EXACT      = 2'd1;

    typedef struct packed {
        logic                  nonempty;
        logic                  match;
        logic                  skip;
        logic signed [Q_W-1:0] q;
    } t_eval;

    function automatic logic signed [15:0] f_mate_adjust(
        input logic signed [15:0] score,
        input logic [7:0]         ply,
        input logic [14:0]        thr
    );
        logic signed [17:0] s;
        logic signed [17:0] t;
        logic signed [17:0] sum;
        logic signed [17:0] dif;
        logic signed [15:0] r;
        s   = {{2{score[15]}}, score};
        t   = {3'b000, thr};
        sum = s + {10'b0, ply};
        dif = s - {10'b0, ply};
        if (s >= t) begin
            r = (sum > 18'sd32767) ? 16'sh7FFF : sum[15:0];
        end else if (s <= -t) begin
            r = (dif < -18'sd32768) ? 16'sh8000 : dif[15:0];
        end else begin
            r = score;
        end
        return r;
    endfunction

    // Stored depth byte is depth + 128, with -128 clamped to -127; the signed depth is the byte with its MSB flipped.
    function automatic logic [7:0] f_depth_byte(input logic signed [7:0] depth);
        logic [7:0] d;
        d = (depth == -8'sd128) ? 8'h81 : depth;
        return {~d[7], d[6:0]};
    endfunction

endpackage
`default_nettype wire

/* sv/chtr_mem.sv */
// Slot memory: one write port, one read port with registered read data.
// Each word holds the check word above the entry word. Uses chtr_pkg.
`default_nettype none
module chtr_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [ADDR_W-1:0]          i_waddr,
    input  wire logic [chtr_pkg::SLOT_W-1:0] i_wdata,
    input  wire logic                       i_re,
    input  wire logic [ADDR_W-1:0]          i_raddr,
    output logic      [chtr_pkg::SLOT_W-1:0] o_rdata
);
    import chtr_pkg::*;

    logic [SLOT_W-1:0] r_mem [DEPTH];
    logic [SLOT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* sv/chtr_way_eval.sv */
// Shared per-way evaluation unit: key match, refresh skip test and replacement score.
// Used once per scanned way by the sequencer. Uses chtr_pkg.
`default_nettype none
module chtr_way_eval (
    input  wire logic [chtr_pkg::CHECK_W-1:0] i_check,
    input  wire logic [chtr_pkg::ENTRY_W-1:0] i_entry,
    input  wire logic [63:0]                  i_key,
    input  wire logic signed [7:0]            i_depth,
    input  wire logic [1:0]                   i_bound,
    input  wire logic [1:0]                   i_exact_code,
    input  wire logic [5:0]                   i_generation,
    output chtr_pkg::t_eval                   o_eval
);
    import chtr_pkg::*;

    logic signed [Q_W-1:0] edepth;
    logic signed [Q_W-1:0] dplus;
    logic [5:0]            age;

    always_comb begin
        edepth = $signed({2'b00, i_entry[39:32]}) - 10'sd128;
        dplus  = $signed({{2{i_depth[7]}}, i_depth}) + 10'sd2;
        age    = i_generation - i_entry[47:42];
        o_eval.nonempty = (i_entry != '0);
        o_eval.match    = (i_entry != '0) && ((i_check ^ {16'b0, i_entry}) == i_key);
        o_eval.skip     = (i_bound != i_exact_code) && (dplus < edepth);
        o_eval.q        = edepth - $signed({2'b00, age, 2'b00});
    end

endmodule
`default_nettype wire

/* sv/clustered_hash_table_replace.sv */
// A probe stages its result when its scan ends; a store passes a write state before it
// (a skipped refresh has no write state). One transaction at a time: the next is taken
// the cycle after the result is staged. The per-way scan runs through the single memory
// read port, one way a cycle. Reset: synchronous active low; afterwards a clearing pass
// writes every slot to zero, during which o_ready stays low. Config writes are taken in
// every state out of reset.
`default_nettype none
module clustered_hash_table_replace #(
    parameter int SET_INDEX_BITS = 10,
    parameter int WAYS           = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [14:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_op,
    input  wire logic [63:0] i_key,
    input  wire logic [15:0] i_move_in,
    input  wire logic signed [15:0] i_score_in,
    input  wire logic signed [7:0]  i_depth_in,
    input  wire logic [1:0]  i_bound_in,
    input  wire logic [7:0]  i_ply,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_done_res,
    output logic [15:0]      o_move_out,
    output logic signed [15:0] o_score_out,
    output logic signed [7:0]  o_depth_out,
    output logic [1:0]       o_bound_out,
    output logic [5:0]       o_entry_generation
);
    import chtr_pkg::*;

    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ADDR_W = SET_INDEX_BITS + WAY_W;
    localparam int SLOTS  = WAYS << SET_INDEX_BITS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    function automatic logic [ADDR_W-1:0] f_slot(
        input logic [SET_INDEX_BITS-1:0] set,
        input logic [WAY_W-1:0]          way
    );
        return ADDR_W'(set) * ADDR_W'(WAYS) + ADDR_W'(way);
    endfunction

    logic [2:0]  r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [5:0]  r_generation;
    logic [14:0] r_mate_thr;
    logic [1:0]  r_exact;

    logic        r_op;
    logic [63:0] r_key;
    logic [15:0] r_move;
    logic signed [15:0] r_score;
    logic signed [7:0]  r_depth;
    logic [1:0]  r_bound;
    logic [7:0]  r_ply;
    logic [WAY_W-1:0] r_way;
    logic [WAY_W-1:0] r_victim;
    logic signed [Q_W-1:0] r_q;

    logic        r_res_done;
    logic [15:0] r_res_move;
    logic [15:0] r_res_score;
    logic [7:0]  r_res_depth;
    logic [1:0]  r_res_bound;
    logic [5:0]  r_res_gen;

    logic        r_ov;
    logic        r_o_done;
    logic [15:0] r_o_move;
    logic [15:0] r_o_score;
    logic [7:0]  r_o_depth;
    logic [1:0]  r_o_bound;
    logic [5:0]  r_o_gen;

    logic        mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [SLOT_W-1:0] mem_wdata, mem_rdata;
    logic [CHECK_W-1:0] rd_check;
    logic [ENTRY_W-1:0] rd_entry;
    logic [ENTRY_W-1:0] wr_entry;
    t_eval       ev;
    logic        in_acc;
    logic        last_way;
    logic        resp_load;

    assign in_acc    = i_valid && o_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign last_way  = (r_way == WAY_W'(WAYS - 1));
    assign resp_load = (r_state == S_RESP) && (!r_ov || i_ready);
    assign rd_check  = mem_rdata[SLOT_W-1:ENTRY_W];
    assign rd_entry  = mem_rdata[ENTRY_W-1:0];

    assign wr_entry = {r_generation, r_bound, f_depth_byte(r_depth),
                       f_mate_adjust(r_score, r_ply, r_mate_thr), r_move};

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = f_slot(r_key[SET_INDEX_BITS-1:0], r_victim);
        mem_wdata = {r_key ^ {16'b0, wr_entry}, wr_entry};
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (r_state == S_WRITE) begin
            mem_we = 1'b1;
        end
    end

    always_comb begin
        mem_re    = in_acc;
        mem_raddr = f_slot(i_key[SET_INDEX_BITS-1:0], '0);
        if (r_state == S_SCAN) begin
            mem_re    = !last_way;
            mem_raddr = f_slot(r_key[SET_INDEX_BITS-1:0], r_way + 1'b1);
        end
    end

    chtr_mem #(
        .DEPTH  (SLOTS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    chtr_way_eval u_eval (
        .i_check      (rd_check),
        .i_entry      (rd_entry),
        .i_key        (r_key),
        .i_depth      (r_depth),
        .i_bound      (r_bound),
        .i_exact_code (r_exact),
        .i_generation (r_generation),
        .o_eval       (ev)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(SLOTS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_op == OP_PROBE) begin
                    if (ev.match || last_way) n_state = S_RESP;
                end else if (!ev.nonempty) begin
                    n_state = S_WRITE;
                end else if (ev.match) begin
                    n_state = ev.skip ? S_RESP : S_WRITE;
                end else if (last_way) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: n_state = S_RESP;
            S_RESP: begin
                if (resp_load) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_generation <= RST_GENERATION;
            r_mate_thr   <= RST_MATE_THR;
            r_exact      <= RST_EXACT;
            r_ov         <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_GENERATION: r_generation <= i_cfg_data[5:0];
                    REG_MATE_THR:   r_mate_thr   <= i_cfg_data;
                    REG_EXACT:      r_exact      <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (resp_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_move  <= i_move_in;
            r_score <= i_score_in;
            r_depth <= i_depth_in;
            r_bound <= i_bound_in;
            r_ply   <= i_ply;
            r_way   <= '0;
            r_victim <= '0;
            r_q     <= '0;
            r_res_done  <= 1'b0;
            r_res_move  <= '0;
            r_res_score <= '0;
            r_res_depth <= '0;
            r_res_bound <= '0;
            r_res_gen   <= '0;
        end
        if (r_state == S_SCAN) begin
            r_way <= r_way + 1'b1;
            if (r_op == OP_PROBE) begin
                if (ev.match) begin
                    r_res_done  <= 1'b1;
                    r_res_move  <= rd_entry[15:0];
                    r_res_score <= rd_entry[31:16];
                    r_res_depth <= {~rd_entry[39], rd_entry[38:32]};
                    r_res_bound <= rd_entry[41:40];
                    r_res_gen   <= rd_entry[47:42];
                end
            end else if (!ev.nonempty) begin
                r_victim <= r_way;
            end else if (ev.match) begin
                r_victim <= r_way;
                if (r_move == '0) r_move <= rd_entry[15:0];
            end else if ((r_way == '0) || (ev.q < r_q)) begin
                r_victim <= r_way;
                r_q      <= ev.q;
            end
        end
        if (r_state == S_WRITE) r_res_done <= 1'b1;
        if (resp_load) begin
            r_o_done  <= r_res_done;
            r_o_move  <= r_res_move;
            r_o_score <= r_res_score;
            r_o_depth <= r_res_depth;
            r_o_bound <= r_res_bound;
            r_o_gen   <= r_res_gen;
        end
    end

    assign o_valid            = r_ov;
    assign o_done_res         = r_o_done;
    assign o_move_out         = r_o_move;
    assign o_score_out        = r_o_score;
    assign o_depth_out        = r_o_depth;
    assign o_bound_out        = r_o_bound;
    assign o_entry_generation = r_o_gen;

endmodule
`default_nettype wire

/* sv/chtr_checker.sv */
// Port-level checker for clustered_hash_table_replace, attached by the bind below.
// Sees only the top-level ports; uses no package items.
`default_nettype none
module chtr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_done_res,
    input wire logic [15:0] o_move_out,
    input wire logic [15:0] o_score_out,
    input wire logic [7:0]  o_depth_out,
    input wire logic [1:0]  o_bound_out,
    input wire logic [5:0]  o_entry_generation
);

    // clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_ready)
        else $error("ready raised before the clearing pass");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while a transaction is in flight");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_done_res) |-> (o_move_out == 16'h0) && (o_score_out == 16'h0)
            && (o_depth_out == 8'h0) && (o_bound_out == 2'h0)
            && (o_entry_generation == 6'h0))
        else $error("miss or skipped store with nonzero fields");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_depth_out != 8'h80))
        else $error("depth out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_done_res) && $stable(o_move_out)
            && $stable(o_score_out) && $stable(o_depth_out))
        else $error("result changed while stalled");

endmodule

bind clustered_hash_table_replace chtr_checker u_chtr_checker (.*);
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for clustered_hash_table_replace: probes and stores against a
// behavioral copy of the 4-way position table, with random flow control on both ports.
// Depends on sv/chtr_pkg.sv and sv/clustered_hash_table_replace.sv.
module tb_top;
    import chtr_pkg::*;

    localparam int SET_BITS     = 10;
    localparam int WAYS_N       = 4;
    localparam int SLOTS        = WAYS_N << SET_BITS;
    localparam int POOL_N       = 48;
    localparam int PHASE_ITEMS  = 260;
    localparam int TAIL_ITEMS   = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = WAYS_N + 6;
    localparam int MAX_REPORTS  = 10;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic        op;
        logic [63:0] key;
        logic [15:0] move;
        logic [15:0] score;
        logic [7:0]  depth;
        logic [1:0]  bound;
        logic [7:0]  ply;
    } t_access;

    typedef struct packed {
        logic        done;
        logic [15:0] move;
        logic [15:0] score;
        logic [7:0]  depth;
        logic [1:0]  bound;
        logic [5:0]  gen;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [14:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_op;
    logic [63:0] i_key;
    logic [15:0] i_move_in;
    logic signed [15:0] i_score_in;
    logic signed [7:0]  i_depth_in;
    logic [1:0]  i_bound_in;
    logic [7:0]  i_ply;
    logic        o_valid;
    logic        i_ready;
    logic        o_done_res;
    logic [15:0] o_move_out;
    logic signed [15:0] o_score_out;
    logic signed [7:0]  o_depth_out;
    logic [1:0]  o_bound_out;
    logic [5:0]  o_entry_generation;

    // behavioral copy of the table and its registers
    logic [63:0] tt_check [0:SLOTS-1];
    logic [47:0] tt_entry [0:SLOTS-1];
    logic [5:0]  cur_gen;
    logic [14:0] mate_thr;
    logic [1:0]  exact_cd;

    t_reply      pending_replies [$];
    logic [63:0] key_pool [0:POOL_N-1];
    int          fail_cnt;
    bit          idle_on;
    bit          hold_req;
    int          hold_cnt;
    int          quiet_left;
    t_reply      got_reply;
    t_reply      want_reply;

    clustered_hash_table_replace #(
        .SET_INDEX_BITS(SET_BITS),
        .WAYS          (WAYS_N)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_op              (i_op),
        .i_key             (i_key),
        .i_move_in         (i_move_in),
        .i_score_in        (i_score_in),
        .i_depth_in        (i_depth_in),
        .i_bound_in        (i_bound_in),
        .i_ply             (i_ply),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_done_res        (o_done_res),
        .o_move_out        (o_move_out),
        .o_score_out       (o_score_out),
        .o_depth_out       (o_depth_out),
        .o_bound_out       (o_bound_out),
        .o_entry_generation(o_entry_generation)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int entry_depth(input logic [47:0] e);
        int d;
        d = e[39:32];
        return d - 128;
    endfunction

    // Looks up or updates the table copy for one transaction and returns the reply.
    function automatic t_reply hash_slot_access(input t_access a);
        t_reply      r;
        int          base;
        int          w;
        int          sc;
        int          dp;
        int          thr;
        int          q;
        int          vq;
        int          victim;
        int          dcl;
        logic [47:0] e;
        logic [5:0]  age;
        logic [15:0] mv;
        logic [47:0] data;
        r    = '0;
        base = int'(a.key[SET_BITS-1:0]) * WAYS_N;
        if (a.op == OP_PROBE) begin
            for (w = 0; w < WAYS_N; w++) begin
                e = tt_entry[base + w];
                if (e != '0 && (tt_check[base + w] ^ {16'b0, e}) == a.key) begin
                    r.done  = 1'b1;
                    r.move  = e[15:0];
                    r.score = e[31:16];
                    r.depth = {~e[39], e[38:32]};
                    r.bound = e[41:40];
                    r.gen   = e[47:42];
                    return r;
                end
            end
            return r;
        end
        mv  = a.move;
        sc  = $signed(a.score);
        dp  = $signed(a.depth);
        thr = mate_thr;
        if (sc >= thr) begin
            sc = sc + int'(a.ply);
            if (sc > 32767) sc = 32767;
        end else if (sc <= -thr) begin
            sc = sc - int'(a.ply);
            if (sc < -32768) sc = -32768;
        end
        victim = 0;
        vq     = 0;
        for (w = 0; w < WAYS_N; w++) begin
            e = tt_entry[base + w];
            if (e == '0) begin
                victim = w;
                break;
            end
            if ((tt_check[base + w] ^ {16'b0, e}) == a.key) begin
                if (a.bound != exact_cd && dp + 2 < entry_depth(e)) return r;
                if (mv == 16'h0000) mv = e[15:0];
                victim = w;
                break;
            end
            age = cur_gen - e[47:42];
            q   = entry_depth(e) - 4 * int'(age);
            if (w == 0 || q < vq) begin
                victim = w;
                vq     = q;
            end
        end
        dcl  = (dp < -127) ? -127 : dp;
        data = {cur_gen, a.bound, 8'(dcl + 128), 16'(sc), mv};
        tt_check[base + victim] = a.key ^ {16'b0, data};
        tt_entry[base + victim] = data;
        r.done = 1'b1;
        return r;
    endfunction

    function automatic t_access mk(input logic op, input logic [63:0] key,
                                   input logic [15:0] move, input int score,
                                   input int depth, input logic [1:0] bound,
                                   input logic [7:0] ply);
        t_access a;
        a.op    = op;
        a.key   = key;
        a.move  = move;
        a.score = 16'(score);
        a.depth = 8'(depth);
        a.bound = bound;
        a.ply   = ply;
        return a;
    endfunction

    function automatic logic [15:0] rand_score();
        int v;
        int thr;
        thr = mate_thr;
        case ($urandom_range(0, 5))
            0: v = int'($urandom_range(0, 65535)) - 32768;
            1: v = thr + int'($urandom_range(0, 4)) - 2;
            2: v = -thr + int'($urandom_range(0, 4)) - 2;
            3: begin
                case ($urandom_range(0, 3))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = -32767;
                    default: v = 0;
                endcase
            end
            default: v = int'($urandom_range(0, 4000)) - 2000;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    function automatic t_access rand_access();
        t_access a;
        a.op    = ($urandom_range(0, 99) < 55) ? OP_STORE : OP_PROBE;
        a.key   = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_N-1)]
                                               : {$urandom, $urandom};
        a.move  = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
        a.score = rand_score();
        a.depth = 8'($urandom);
        a.bound = 2'($urandom);
        if ($urandom_range(0, 3) == 0) a.ply = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
        else a.ply = 8'($urandom);
        return a;
    endfunction

    task automatic model_reset();
        int i;
        for (i = 0; i < SLOTS; i++) begin
            tt_check[i] = '0;
            tt_entry[i] = '0;
        end
        cur_gen  = RST_GENERATION;
        mate_thr = RST_MATE_THR;
        exact_cd = RST_EXACT;
    endtask

    task automatic build_key_pool();
        int i;
        logic [9:0] set_idx;
        for (i = 0; i < POOL_N; i++) begin
            case (i % 8)
                0: set_idx = 10'd0;
                1: set_idx = 10'd1023;
                2: set_idx = 10'd1;
                3: set_idx = 10'd512;
                4: set_idx = 10'd341;
                5: set_idx = 10'd682;
                6: set_idx = 10'd170;
                default: set_idx = 10'd853;
            endcase
            key_pool[i] = {$urandom, $urandom};
            key_pool[i][SET_BITS-1:0] = set_idx;
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [14:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        case (idx)
            REG_GENERATION: cur_gen  = data[5:0];
            REG_MATE_THR:   mate_thr = data;
            REG_EXACT:      exact_cd = data[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_registers(input logic [5:0] gen, input logic [14:0] thr,
                                 input logic [1:0] exact);
        cfg_write(REG_GENERATION, {9'($urandom), gen});
        cfg_write(REG_MATE_THR, thr);
        cfg_write(REG_EXACT, {13'($urandom), exact});
    endtask

    task automatic send_access(input t_access a);
        @(negedge i_clk);
        if (idle_on && quiet_left == 0 && $urandom_range(0, 5) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end else if (quiet_left > 0) begin
            quiet_left--;
        end else if ($urandom_range(0, 29) == 0) begin
            quiet_left = $urandom_range(10, 40);
        end
        i_op       = a.op;
        i_key      = a.key;
        i_move_in  = a.move;
        i_score_in = a.score;
        i_depth_in = a.depth;
        i_bound_in = a.bound;
        i_ply      = a.ply;
        i_valid    = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        pending_replies.push_back(hash_slot_access(a));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_basics();
        logic [63:0] ka;
        logic [63:0] kb;
        logic [63:0] k5 [0:4];
        int i;
        ka = 64'hFFFF_FFFF_FFFF_FFFF;
        kb = 64'h8000_0000_0000_0000;
        for (i = 0; i < 5; i++) k5[i] = {32'hA5A5_0000 + 32'(i), 22'h0, 10'd5};
        send_access(mk(OP_PROBE, 64'h0, 16'h0, 0, 0, 2'd0, 8'd0));
        // positive mate, saturates at the top
        send_access(mk(OP_STORE, ka, 16'hFFFF, 32767, 127, 2'd3, 8'd255));
        send_access(mk(OP_PROBE, ka, 16'h0, 0, 0, 2'd0, 8'd0));
        // negative mate saturation and depth clamp
        send_access(mk(OP_STORE, kb, 16'h0001, -32768, -128, 2'd0, 8'd255));
        send_access(mk(OP_PROBE, kb, 16'h0, 0, 0, 2'd0, 8'd0));
        send_access(mk(OP_STORE, kb, 16'h1234, -31000, 100, 2'd2, 8'd10));
        // non-exact and shallower by more than 2: skipped
        send_access(mk(OP_STORE, kb, 16'h4321, 0, 97, 2'd2, 8'd0));
        // exact, zero move keeps the old one
        send_access(mk(OP_STORE, kb, 16'h0000, 30999, 10, 2'd1, 8'd7));
        send_access(mk(OP_PROBE, kb, 16'h0, 0, 0, 2'd0, 8'd0));
        send_access(mk(OP_STORE, kb, 16'h0000, 31000, 8, 2'd0, 8'd3));
        send_access(mk(OP_PROBE, kb, 16'h0, 0, 0, 2'd0, 8'd0));
        send_access(mk(OP_STORE, k5[0], 16'h0010, 5, 10, 2'd0, 8'd0));
        send_access(mk(OP_STORE, k5[1], 16'h0011, 5, 3, 2'd0, 8'd0));
        send_access(mk(OP_STORE, k5[2], 16'h0012, 5, 7, 2'd0, 8'd0));
        send_access(mk(OP_STORE, k5[3], 16'h0013, 5, 3, 2'd0, 8'd0));
        // full set: evicts the first of the two shallowest
        send_access(mk(OP_STORE, k5[4], 16'h0014, 5, 20, 2'd0, 8'd0));
        send_access(mk(OP_PROBE, k5[1], 16'h0, 0, 0, 2'd0, 8'd0));
        send_access(mk(OP_PROBE, k5[3], 16'h0, 0, 0, 2'd0, 8'd0));
        send_access(mk(OP_PROBE, k5[4], 16'h0, 0, 0, 2'd0, 8'd0));
        send_access(mk(OP_PROBE, {32'hA5A5_0009, 22'h0, 10'd5}, 16'h0, 0, 0, 2'd0, 8'd0));
        wait_idle();
    endtask

    task automatic test_register_extremes();
        logic [63:0] kz;
        logic [63:0] kn;
        kz = 64'h0;
        kn = {32'h5A5A_FFFF, 22'h3F_FFFF, 10'd5};
        cfg_write(REG_GENERATION, 15'h7FFF);
        cfg_write(REG_MATE_THR, 15'd0);
        cfg_write(REG_EXACT, 15'h7FFC);
        cfg_write(REG_UNUSED, 15'h7FFF);
        // zero threshold: zero score is a positive mate
        send_access(mk(OP_STORE, kz, 16'hABCD, 0, 0, 2'd1, 8'd9));
        send_access(mk(OP_PROBE, kz, 16'h0, 0, 0, 2'd0, 8'd0));
        send_access(mk(OP_STORE, kn, 16'h0F0F, -1, 0, 2'd3, 8'd255));
        send_access(mk(OP_PROBE, kn, 16'h0, 0, 0, 2'd0, 8'd0));
        send_access(mk(OP_STORE, kn, 16'h0000, 7, -100, 2'd0, 8'd1));
        send_access(mk(OP_PROBE, kn, 16'h0, 0, 0, 2'd0, 8'd0));
        wait_idle();
        cfg_write(REG_MATE_THR, 15'h7FFF);
        cfg_write(REG_EXACT, 15'h0003);
        cfg_write(REG_GENERATION, 15'h7FC0);
        send_access(mk(OP_STORE, kz, 16'h1111, 32767, 50, 2'd3, 8'd1));
        send_access(mk(OP_PROBE, kz, 16'h0, 0, 0, 2'd0, 8'd0));
        send_access(mk(OP_STORE, kn, 16'h2222, -32767, 1, 2'd2, 8'd3));
        send_access(mk(OP_PROBE, kn, 16'h0, 0, 0, 2'd0, 8'd0));
        send_access(mk(OP_STORE, 64'h0000_0000_0000_0400, 16'h3333, 32766, -5, 2'd0, 8'd255));
        send_access(mk(OP_PROBE, 64'h0000_0000_0000_0400, 16'h0, 0, 0, 2'd0, 8'd0));
        wait_idle();
    endtask

    task automatic test_random_phases();
        int         ph;
        int         n;
        logic [5:0] gen;
        logic [14:0] thr;
        logic [1:0] exact;
        gen = 6'd0;
        for (ph = 0; ph < 5; ph++) begin
            gen = gen + 6'($urandom_range(1, 40));
            case (ph)
                0: begin
                    thr   = 15'd0;
                    exact = 2'd0;
                end
                4: begin
                    thr   = 15'd32767;
                    exact = 2'd3;
                end
                default: begin
                    thr   = ($urandom_range(0, 3) == 0) ? RST_MATE_THR
                                                         : 15'($urandom_range(1, 32766));
                    exact = 2'($urandom);
                end
            endcase
            set_registers(gen, thr, exact);
            if (ph == 2) hold_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) send_access(rand_access());
            wait_idle();
        end
    endtask

    task automatic test_back_to_back();
        int n;
        idle_on = 1'b0;
        set_registers(6'($urandom), RST_MATE_THR, RST_EXACT);
        for (n = 0; n < TAIL_ITEMS; n++) send_access(rand_access());
        wait_idle();
    endtask

    // result receiver: random stalls, quiet stretches, and one long hold-off
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready  = 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
            end else begin
                i_ready = 1'b1;
                if (idle_on && $urandom_range(0, 19) == 0)
                    repeat ($urandom_range(10, 40)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got_reply = {o_done_res, o_move_out, o_score_out, o_depth_out, o_bound_out,
                         o_entry_generation};
            if (pending_replies.size() == 0) begin
                if (fail_cnt < MAX_REPORTS)
                    $display("%0t: unexpected result transaction done=%0d move=%h", $time,
                             got_reply.done, got_reply.move);
                fail_cnt++;
            end else begin
                want_reply = pending_replies.pop_front();
                if (got_reply !== want_reply) begin
                    if (fail_cnt < MAX_REPORTS) begin
                        $display("%0t: exp done=%0d move=%h score=%0d depth=%0d bound=%0d gen=%0d",
                                 $time, want_reply.done, want_reply.move,
                                 $signed(want_reply.score), $signed(want_reply.depth),
                                 want_reply.bound, want_reply.gen);
                        $display("%0t: got done=%0d move=%h score=%0d depth=%0d bound=%0d gen=%0d",
                                 $time, got_reply.done, got_reply.move,
                                 $signed(got_reply.score), $signed(got_reply.depth),
                                 got_reply.bound, got_reply.gen);
                    end
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_GENERATION;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_op        = OP_PROBE;
        i_key       = '0;
        i_move_in   = '0;
        i_score_in  = '0;
        i_depth_in  = '0;
        i_bound_in  = '0;
        i_ply       = '0;
        fail_cnt    = 0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        quiet_left  = 0;
        model_reset();
        build_key_pool();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_basics();
        test_register_extremes();
        test_random_phases();
        test_back_to_back();

        if (fail_cnt == 0 && pending_replies.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
